@@ src/percent_decode_bytes_unit_assert.svh @@
// ---------------------------------------------------------------------------
// percent_decode_bytes_unit assertion macros
// Shared concurrent assertion forms for the percent decoder checks.
// ---------------------------------------------------------------------------
`ifndef PERCENT_DECODE_BYTES_UNIT_ASSERT_SVH
`define PERCENT_DECODE_BYTES_UNIT_ASSERT_SVH

// Assertion sampled on clk, switched off while rst is high
`define PDEC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on clk, live during reset as well
`define PDEC_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pdec_pkg.sv @@
// ---------------------------------------------------------------------------
// pdec_pkg
// Types, constants and helpers shared by the percent decoder modules.
// ---------------------------------------------------------------------------
package pdec_pkg;

   // Character codes
   localparam logic [7:0] PCT_CHAR = 8'h25;   // '%'
   localparam logic [7:0] BAD_MARK = 8'h3F;   // '?'

   // Most results one input beat can cause (bad escape)
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS + 1);

   // Result queue: room for one waiting result plus a full burst
   localparam int unsigned QUEUE_DEPTH = MAX_RESULTS + 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Escape tracking
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,   // not inside an escape
      PH_PCT  = 2'd1,   // '%' seen
      PH_HELD = 2'd2    // first escape byte held
   } phase_type;

   // One result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
   } result_type;

   // Everything one input beat produces
   typedef struct packed {
      logic [RES_IDX_W-1:0]             count;
      result_type [MAX_RESULTS-1:0]     res;
   } decode_type;

   // Hex digit to nibble: bit 4 is the valid flag, bits 3:0 the value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

@@ src/pdec_decode.sv @@
// ---------------------------------------------------------------------------
// pdec_decode
// Escape tracking state and the per-beat decode into up to three results.
// ---------------------------------------------------------------------------
module pdec_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,       // input beat accepted
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output pdec_pkg::decode_type   dec
);

   pdec_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          first_ff, first_in;
   logic [4:0]          hex_hi, hex_lo;

   assign hex_hi = pdec_pkg::hex_decode(first_ff);
   assign hex_lo = pdec_pkg::hex_decode(in_byte);

   // Decode and next state
   always_comb begin
      dec      = '0;
      phase_in = phase_ff;
      first_in = first_ff;
      case (phase_ff)
         pdec_pkg::PH_PCT: begin
            first_in = in_byte;
            phase_in = pdec_pkg::PH_HELD;
         end
         pdec_pkg::PH_HELD: begin
            if (hex_hi[4] && hex_lo[4]) begin
               dec.count  = pdec_pkg::RES_IDX_W'(1);
               dec.res[0] = '{out_byte: {hex_hi[3:0], hex_lo[3:0]},
                              has_byte: 1'b1, out_last: 1'b0};
            end else begin
               dec.count  = pdec_pkg::RES_IDX_W'(3);
               dec.res[0] = '{out_byte: pdec_pkg::BAD_MARK, has_byte: 1'b1,
                              out_last: 1'b0};
               dec.res[1] = '{out_byte: first_ff, has_byte: 1'b1, out_last: 1'b0};
               dec.res[2] = '{out_byte: in_byte, has_byte: 1'b1, out_last: 1'b0};
            end
            phase_in = pdec_pkg::PH_IDLE;
            first_in = 8'd0;
         end
         default: begin
            if (in_byte == pdec_pkg::PCT_CHAR) begin
               phase_in = pdec_pkg::PH_PCT;
            end else begin
               dec.count  = pdec_pkg::RES_IDX_W'(1);
               dec.res[0] = '{out_byte: in_byte, has_byte: 1'b1, out_last: 1'b0};
               phase_in   = pdec_pkg::PH_IDLE;
            end
         end
      endcase

      // End of string: mark the final result, or send a bare end mark
      if (in_last) begin
         case (dec.count)
            pdec_pkg::RES_IDX_W'(1): dec.res[0].out_last = 1'b1;
            pdec_pkg::RES_IDX_W'(3): dec.res[2].out_last = 1'b1;
            default: begin
               dec.count  = pdec_pkg::RES_IDX_W'(1);
               dec.res[0] = '{out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1};
            end
         endcase
         phase_in = pdec_pkg::PH_IDLE;
         first_in = 8'd0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pdec_pkg::PH_IDLE;
         first_ff <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
   end

endmodule

@@ src/percent_decode_bytes_unit.sv @@
// ---------------------------------------------------------------------------
// percent_decode_bytes_unit
// Streaming percent (URL) decoder, one encoded byte per input beat.
// ---------------------------------------------------------------------------
// Input channel req_*: one encoded byte per beat, req_tlast on the final byte
// of a string. Result channel rsp_*: one decoded byte per beat in rsp_tdata,
// rsp_tuser high when the beat carries data, rsp_tlast on the final result of
// the string. A string whose last input yields no byte ends with a single
// beat with rsp_tuser low and rsp_tdata zero.
// A result enters the result queue on the cycle after the input beat that
// causes it. Throughput: one input beat per cycle while req_tready is high;
// a malformed escape gives three result beats, which drain at one per cycle
// while rsp_tready is high, through a four-entry result queue. req_tready
// is high while the queue holds at most one result, so a waiting result
// does not stop input; a bad escape stalls input until one result is left.
// Reset (synchronous) empties the queue and leaves any escape.
// When rsp_tready is low the head result holds steady; input stops once the
// queue cannot take a full three-beat burst.
// ---------------------------------------------------------------------------
module percent_decode_bytes_unit (
   input  logic       clock,
   input  logic       reset,
   // Input channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,    // in_last
   // Result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tuser,    // [0] has_byte
   output logic       rsp_tlast     // out_last
);

   localparam int unsigned QD = pdec_pkg::QUEUE_DEPTH;
   localparam int unsigned CW = pdec_pkg::QCNT_W;

   pdec_pkg::decode_type dec;
   pdec_pkg::result_type q_ff [QD];
   pdec_pkg::result_type q_in [QD];
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        base;
   logic [CW-1:0]        n_push;
   logic                 accept, pop;

   assign req_tready = (cnt_ff <= CW'(1));
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid & rsp_tready;

   // Decode of the incoming beat
   pdec_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .dec     (dec)
   );

   // Queue update: shift out the head, append this beat's results
   assign base   = cnt_ff - CW'(pop);
   assign n_push = accept ? CW'(dec.count) : '0;
   assign cnt_in = base + n_push;

   always_comb begin
      logic [CW-1:0] off;
      for (int i = 0; i < QD; i++) begin
         q_in[i] = q_ff[i];
         if (pop && (i < QD - 1)) begin
            q_in[i] = q_ff[(i < QD - 1) ? i + 1 : i];
         end
         off = CW'(i) - base;
         if ((CW'(i) >= base) && (off < n_push)) begin
            q_in[i] = dec.res[off[pdec_pkg::RES_IDX_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // Head of queue to the result port
   assign rsp_tdata = q_ff[0].out_byte;
   assign rsp_tuser = q_ff[0].has_byte;
   assign rsp_tlast = q_ff[0].out_last;

endmodule

@@ src/pdec_checker.sv @@
// ---------------------------------------------------------------------------
// pdec_checker
// Port-level checks for the percent decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "percent_decode_bytes_unit_assert.svh"

module pdec_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // Stalled result beat keeps valid and payload
   `PDEC_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp beat changed under stall")

   // A beat without data is always a bare end mark
   `PDEC_ASSERT_RST(a_end_mark, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == 8'd0), "empty beat is not an end mark")

   // Reset leaves an empty queue ready for input
   `PDEC_ASSERT(a_reset_empty, clock, reset |=> req_tready && !rsp_tvalid, "not empty after reset")

   // An accepted last beat always yields a result on the next cycle
   `PDEC_ASSERT_RST(a_last_out, clock, reset, req_tvalid && req_tready && req_tlast |=> rsp_tvalid, "no result after last byte")

endmodule

bind percent_decode_bytes_unit pdec_checker u_pdec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
